@@ design/csl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types and codes for the crash latch supervisor.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int ACCEL_W  = 16;
  localparam int ANGLE_W  = 14;
  localparam int MISSED_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] ACT_BOOT    = 2'd0;
  localparam logic [1:0] ACT_SAMPLE  = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  localparam logic [1:0] CODE_INIT    = 2'd0;
  localparam logic [1:0] CODE_OK      = 2'd1;
  localparam logic [1:0] CODE_CRASHED = 2'd2;
  localparam logic [1:0] CODE_ERROR   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_EXIT_ACCEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXIT_ANGLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MISSED     = 2'd2;

  localparam logic [ACCEL_W-1:0]  EXIT_ACCEL_RESET = 16'd3138;
  localparam logic [ANGLE_W-1:0]  EXIT_ANGLE_RESET = 14'd1600;
  localparam logic [MISSED_W-1:0] MISSED_RESET     = 4'd3;

  typedef enum logic [3:0] {
    MODE_INIT    = 4'b0001,
    MODE_OK      = 4'b0010,
    MODE_CRASHED = 4'b0100,
    MODE_ERROR   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [ACCEL_W-1:0] accel;
    logic               settled;
    logic               crash_event;
    logic               imu_fault;
    logic               driver_reset;
    logic               stored_latch;
  } item_t;

  typedef struct packed {
    logic [MISSED_W-1:0] missed_limit;
  } back_cfg_t;

endpackage : csl_pkg
`default_nettype wire

@@ design/csl_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csl_front
// Holds the limit registers and classifies each incoming request: passes
// the event on and checks whether the vehicle is calm, upright and healthy.
// ----------------------------------------------------------------------------
module csl_front
  import csl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [1:0]            action,
  input  wire logic [ACCEL_W-1:0]    accel_peak,
  input  wire logic [ANGLE_W-1:0]    tilt_angle,
  input  wire logic                  crash_event,
  input  wire logic                  imu_fault,
  input  wire logic                  driver_reset,
  input  wire logic                  stored_latch,
  output item_t                      item,
  output back_cfg_t                  back_cfg
);

  logic [ACCEL_W-1:0]  exit_accel_r;
  logic [ANGLE_W-1:0]  exit_angle_r;
  logic [MISSED_W-1:0] missed_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exit_accel_r   <= EXIT_ACCEL_RESET;
      exit_angle_r   <= EXIT_ANGLE_RESET;
      missed_limit_r <= MISSED_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EXIT_ACCEL: exit_accel_r   <= cfg_data[ACCEL_W-1:0];
        REG_EXIT_ANGLE: exit_angle_r   <= cfg_data[ANGLE_W-1:0];
        REG_MISSED:     missed_limit_r <= cfg_data[MISSED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    item.action       = action;
    item.accel        = accel_peak;
    item.settled      = (accel_peak < exit_accel_r) && (tilt_angle < exit_angle_r)
                        && !imu_fault;
    item.crash_event  = crash_event;
    item.imu_fault    = imu_fault;
    item.driver_reset = driver_reset;
    item.stored_latch = stored_latch;
  end

  assign back_cfg.missed_limit = missed_limit_r;

endmodule : csl_front
`default_nettype wire

@@ design/csl_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csl_queue
// Two-entry queue of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
module csl_queue
  import csl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output item_t      pop_item
);

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule : csl_queue
`default_nettype wire

@@ design/csl_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csl_back
// Applies each classified request to the supervisor state and holds the
// result in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module csl_back
  import csl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire item_t               item,
  input  wire back_cfg_t           back_cfg,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_mode_code,
  output logic                     out_safety_enable,
  output logic [ACCEL_W-1:0]       out_tripped_accel,
  output logic [ACCEL_W-1:0]       out_peak_accel,
  output logic                     out_latch_flag,
  output logic                     out_persist_request
);

  mode_t               mode_r, mode_nxt;
  logic [MISSED_W-1:0] missed_r, missed_nxt;
  logic [ACCEL_W-1:0]  max_r, max_nxt;
  logic [ACCEL_W-1:0]  trip_r, trip_nxt;
  logic                latch_r, latch_nxt;
  logic                persist;
  logic [1:0]          code;
  logic                out_valid_r;
  logic                take;

  assign item_ready = !out_valid_r || out_ready;
  assign take       = item_valid && item_ready;
  assign out_valid  = out_valid_r;

  always_comb begin
    mode_nxt   = mode_r;
    missed_nxt = missed_r;
    max_nxt    = max_r;
    trip_nxt   = trip_r;
    latch_nxt  = latch_r;
    persist    = 1'b0;
    case (item.action)
      ACT_BOOT: begin
        missed_nxt = '0;
        max_nxt    = '0;
        trip_nxt   = '0;
        latch_nxt  = item.stored_latch;
        if (item.stored_latch) begin
          mode_nxt = MODE_CRASHED;
        end else if (item.settled) begin
          mode_nxt = MODE_OK;
        end else begin
          mode_nxt = MODE_ERROR;
        end
      end
      ACT_SAMPLE: begin
        missed_nxt = '0;
        if (mode_r == MODE_OK) begin
          if (item.crash_event) begin
            latch_nxt = 1'b1;
            persist   = 1'b1;
            trip_nxt  = item.accel;
            max_nxt   = item.accel;
            mode_nxt  = MODE_CRASHED;
          end else if (item.imu_fault) begin
            mode_nxt = MODE_ERROR;
          end
        end else begin
          if (item.accel > max_r) begin
            max_nxt = item.accel;
          end
          if (item.driver_reset && item.settled) begin
            mode_nxt  = MODE_OK;
            latch_nxt = 1'b0;
            persist   = 1'b1;
            trip_nxt  = '0;
            max_nxt   = '0;
          end
        end
      end
      ACT_TIMEOUT: begin
        if (missed_r < back_cfg.missed_limit) begin
          missed_nxt = missed_r + 4'd1;
        end else begin
          mode_nxt = MODE_ERROR;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (mode_nxt)
      MODE_INIT:    code = CODE_INIT;
      MODE_OK:      code = CODE_OK;
      MODE_CRASHED: code = CODE_CRASHED;
      MODE_ERROR:   code = CODE_ERROR;
      default:      code = CODE_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_INIT;
      missed_r    <= '0;
      max_r       <= '0;
      trip_r      <= '0;
      latch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        mode_r   <= mode_nxt;
        missed_r <= missed_nxt;
        max_r    <= max_nxt;
        trip_r   <= trip_nxt;
        latch_r  <= latch_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_mode_code       <= code;
      out_safety_enable   <= (mode_nxt == MODE_OK);
      out_tripped_accel   <= trip_nxt;
      out_peak_accel      <= max_nxt;
      out_latch_flag      <= latch_nxt;
      out_persist_request <= persist;
    end
  end

endmodule : csl_back
`default_nettype wire

@@ design/crash_latch_supervisor.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crash_latch_supervisor
// Crash latch supervisor with init, ok, crashed and error modes.
// ----------------------------------------------------------------------------
// The input channel carries one event per request: a boot check, a new IMU
// sample or a missed-sample timeout, with the sample fields alongside. Each
// request gives exactly one result on the output channel: the mode after the
// update, the safety enable, the captured and peak accelerations, the latch
// and a nonvolatile write request flag.
// The configuration channel writes the calm, upright and missed-sample
// limits; it is always ready. The user must write it only while the block
// is idle; the block itself does not enforce this. An accepted request is
// written into the queue, taken from there by the back part, and its result
// is registered in the output register. One request is accepted every cycle
// while the receiver takes results; an output stall holds the flow back.
// A two-entry queue parts the front and back parts, and the output register
// holds a result while the receiver stalls; input ready drops only once the
// queue is full. Reset puts the block in init mode with the counters,
// accelerations and latch cleared and the limits at their default values.
// ----------------------------------------------------------------------------
module crash_latch_supervisor
  import csl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_action,
  input  wire logic [ACCEL_W-1:0]    in_accel_peak,
  input  wire logic [ANGLE_W-1:0]    in_tilt_angle,
  input  wire logic                  in_crash_event,
  input  wire logic                  in_imu_fault,
  input  wire logic                  in_driver_reset,
  input  wire logic                  in_stored_latch,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_mode_code,
  output logic                       out_safety_enable,
  output logic [ACCEL_W-1:0]         out_tripped_accel,
  output logic [ACCEL_W-1:0]         out_peak_accel,
  output logic                       out_latch_flag,
  output logic                       out_persist_request
);

  item_t     front_item;
  item_t     back_item;
  back_cfg_t back_cfg;
  logic      back_valid;
  logic      back_ready;

  csl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (in_action),
    .accel_peak   (in_accel_peak),
    .tilt_angle   (in_tilt_angle),
    .crash_event  (in_crash_event),
    .imu_fault    (in_imu_fault),
    .driver_reset (in_driver_reset),
    .stored_latch (in_stored_latch),
    .item         (front_item),
    .back_cfg     (back_cfg)
  );

  csl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_item   (back_item)
  );

  csl_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .item_valid          (back_valid),
    .item_ready          (back_ready),
    .item                (back_item),
    .back_cfg            (back_cfg),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_mode_code       (out_mode_code),
    .out_safety_enable   (out_safety_enable),
    .out_tripped_accel   (out_tripped_accel),
    .out_peak_accel      (out_peak_accel),
    .out_latch_flag      (out_latch_flag),
    .out_persist_request (out_persist_request)
  );

endmodule : crash_latch_supervisor
`default_nettype wire
